// ===== hdl/prrq_pkg.sv =====
// Package with shared constants, codes and types of the round-robin queue.
`default_nettype none
package prrq_pkg;
    localparam int NUM_BUCKETS = 16;
    localparam int NUM_CONNS   = 64;
    localparam int FIFO_DEPTH  = 8;
    localparam int SLOTS       = NUM_CONNS / NUM_BUCKETS;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CONN_W      = BKT_W + SLOT_W;
    localparam int IDX_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int RCNT_W      = SLOT_W + 1;
    localparam int TRY_W       = $clog2(NUM_BUCKETS + 2);
    localparam int TRIES_MAX   = NUM_BUCKETS + 1;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_PURGE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_NOCONN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_PURGE,
        OP_STEP
    } t_op;

    // One bucket: its rotation order, and the state of the connections in it.
    typedef struct packed {
        logic [SLOTS-1:0][SLOT_W-1:0] rot;
        logic [RCNT_W-1:0]            rcnt;
        logic [SLOTS-1:0]             ex;
        logic [SLOTS-1:0]             vis;
        logic [SLOTS-1:0][IDX_W-1:0]  head;
        logic [SLOTS-1:0][CNT_W-1:0]  cnt;
    } t_brec;

    typedef struct packed {
        logic              ok;
        logic              found;
        logic              again;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  drop;
    } t_alu_res;
endpackage
`default_nettype wire

// ===== hdl/prrq_rec_alu.sv =====
// Update of one bucket record for enqueue, purge or one scheduling step.
`default_nettype none
module prrq_rec_alu
    import prrq_pkg::*;
(
    input  wire t_brec         i_rec,
    input  wire t_op           i_op,
    input  wire [SLOT_W-1:0]   i_slot,
    output t_brec              o_rec,
    output t_alu_res           o_res
);
    always_comb begin
        t_brec             n;
        t_alu_res          r;
        logic [SLOT_W-1:0] s;
        logic [RCNT_W-1:0] k;
        logic [RCNT_W-1:0] pos;
        logic              hit;
        n   = i_rec;
        r   = '0;
        s   = i_slot;
        k   = '0;
        pos = '0;
        hit = 1'b0;
        unique case (i_op)
            OP_ENQ: begin
                if (i_rec.ex[s] && i_rec.cnt[s] >= CNT_W'(FIFO_DEPTH)) begin
                    r.ok = 1'b0;
                end else begin
                    r.ok = 1'b1;
                    if (!i_rec.ex[s]) begin
                        n.ex[s]   = 1'b1;
                        n.vis[s]  = 1'b0;
                        n.head[s] = '0;
                        n.cnt[s]  = '0;
                        n.rot[i_rec.rcnt[SLOT_W-1:0]] = s;
                        n.rcnt = i_rec.rcnt + RCNT_W'(1);
                    end
                    r.idx    = n.head[s] + n.cnt[s][IDX_W-1:0];
                    n.cnt[s] = n.cnt[s] + CNT_W'(1);
                end
            end
            OP_PURGE: begin
                if (!i_rec.ex[s]) begin
                    r.ok = 1'b0;
                end else begin
                    r.ok    = 1'b1;
                    n.ex[s] = 1'b0;
                    if (i_rec.vis[s]) begin
                        n.vis[s] = 1'b0;
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!hit && RCNT_W'(i) < i_rec.rcnt && i_rec.rot[i] == s) begin
                                hit = 1'b1;
                                pos = RCNT_W'(i);
                            end
                        end
                        if (hit) begin
                            for (int i = 0; i < SLOTS - 1; i++) begin
                                if (RCNT_W'(i) >= pos) begin
                                    n.rot[i] = i_rec.rot[i+1];
                                end
                            end
                            n.rcnt = i_rec.rcnt - RCNT_W'(1);
                        end
                    end
                    r.drop    = i_rec.cnt[s];
                    n.head[s] = '0;
                    n.cnt[s]  = '0;
                end
            end
            OP_STEP: begin
                if (i_rec.rcnt != '0) begin
                    s = i_rec.rot[0];
                    for (int i = 0; i < SLOTS - 1; i++) begin
                        n.rot[i] = i_rec.rot[i+1];
                    end
                    n.rcnt   = i_rec.rcnt - RCNT_W'(1);
                    n.vis[s] = 1'b1;
                    r.slot   = s;
                    if (i_rec.cnt[s] != '0) begin
                        r.found   = 1'b1;
                        r.idx     = i_rec.head[s];
                        n.head[s] = i_rec.head[s] + IDX_W'(1);
                        n.cnt[s]  = i_rec.cnt[s] - CNT_W'(1);
                    end else begin
                        r.again = 1'b1;
                    end
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (i_rec.ex[i] && i_rec.vis[i]) begin
                            n.rot[k[SLOT_W-1:0]] = SLOT_W'(i);
                            k        = k + RCNT_W'(1);
                            n.vis[i] = 1'b0;
                            if (i_rec.cnt[i] != '0) begin
                                r.again = 1'b1;
                            end
                        end
                    end
                    n.rcnt = k;
                end
            end
            default: begin
                r = '0;
            end
        endcase
        o_rec = n;
        o_res = r;
    end
endmodule
`default_nettype wire

// ===== hdl/per_connection_round_robin_queue.sv =====
// Top level of the per-connection round-robin packet queue scheduler.
//
// Each beat carries one command and yields one result beat. Connection c lives in bucket
// c mod 16; all state of a bucket (rotation order, membership, FIFO pointers of its four
// connections) is one word of a 16-entry bucket memory, and handles sit in a 512-entry
// packet memory, both read into a register. Enqueue and purge pass through the read,
// execute and response states. A dequeue reads each bucket it tries and, in a bucket that
// holds connections, takes rotation steps inside it; at most 17 buckets are tried. The
// input takes a new beat once the previous result is in the output register.
`default_nettype none
module per_connection_round_robin_queue
    import prrq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [23:0] s_axis_tdata,   // cmd[1:0], conn_id[7:2], packet_handle[23:8]
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [31:0] m_axis_tdata   // status[1:0], out_handle[17:2], out_conn[23:18],
                                       // dropped_count[27:24], zero[31:28]
);
    typedef enum logic [2:0] {S_IDLE, S_RD, S_EXEC, S_SERVE, S_RESP} t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [CONN_W-1:0]   r_conn;
    logic [15:0]         r_hdl;
    logic [BKT_W-1:0]    r_rb;
    logic [BKT_W-1:0]    r_bkt;
    logic [TRY_W-1:0]    r_tries;
    t_brec               r_rec;
    t_brec               r_rd;
    logic [NUM_BUCKETS-1:0] r_bval;
    t_brec               r_bmem [NUM_BUCKETS];
    logic [15:0]         r_pmem [NUM_CONNS*FIFO_DEPTH];
    logic [15:0]         r_pkt;
    t_status             r_status;
    logic [CONN_W-1:0]   r_oconn;
    logic [3:0]          r_drop;
    logic                r_use_pkt;
    logic                r_ovalid;
    logic [31:0]         r_odata;

    t_brec               alu_in;
    t_op                 alu_op;
    t_brec               alu_rec;
    t_alu_res            alu_res;
    logic                rd_en;
    logic [BKT_W-1:0]    rd_addr;
    logic                we;
    logic [BKT_W-1:0]    wa;
    t_brec               wd;
    logic                ofree;

    prrq_rec_alu u_alu (
        .i_rec  (alu_in),
        .i_op   (alu_op),
        .i_slot (r_conn[CONN_W-1:BKT_W]),
        .o_rec  (alu_rec),
        .o_res  (alu_res)
    );

    assign ofree         = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        alu_in  = (r_state == S_SERVE) ? r_rec : r_rd;
        alu_op  = OP_STEP;
        rd_en   = 1'b0;
        rd_addr = r_rb;
        we      = 1'b0;
        wa      = r_bkt;
        wd      = alu_rec;
        if (r_state == S_EXEC) begin
            alu_op = (r_cmd == CMD_PURGE) ? OP_PURGE : OP_ENQ;
        end
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    rd_en   = 1'b1;
                    rd_addr = (t_cmd'(s_axis_tdata[1:0]) == CMD_DEQ) ? r_rb
                                                                     : s_axis_tdata[BKT_W+1:2];
                end
            end
            S_EXEC: begin
                if ((r_cmd == CMD_ENQ || r_cmd == CMD_PURGE) && alu_res.ok) begin
                    we = 1'b1;
                end
                if (r_cmd == CMD_DEQ && r_rd.ex == '0 && r_tries != TRY_W'(TRIES_MAX)) begin
                    rd_en = 1'b1;
                end
            end
            S_SERVE: begin
                if (!alu_res.again) begin
                    we = 1'b1;
                    if (!alu_res.found && r_tries != TRY_W'(TRIES_MAX)) begin
                        rd_en = 1'b1;
                    end
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_bmem[wa] <= wd;
        end
        if (rd_en) begin
            if (we && wa == rd_addr) begin
                r_rd <= wd;
            end else if (!r_bval[rd_addr]) begin
                r_rd <= '0;
            end else begin
                r_rd <= r_bmem[rd_addr];
            end
        end
        if (r_state == S_EXEC && r_cmd == CMD_ENQ && alu_res.ok) begin
            r_pmem[{r_conn, alu_res.idx}] <= r_hdl;
        end
        if (r_state == S_SERVE && alu_res.found) begin
            r_pkt <= r_pmem[{alu_res.slot, r_bkt, alu_res.idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rb     <= '0;
            r_bval   <= '0;
            r_ovalid <= 1'b0;
            r_tries  <= '0;
        end else begin
            if (we) begin
                r_bval[wa] <= 1'b1;
            end
            if (rd_en) begin
                r_bkt <= rd_addr;
                if (r_state != S_IDLE || t_cmd'(s_axis_tdata[1:0]) == CMD_DEQ) begin
                    r_rb <= r_rb + BKT_W'(1);
                end
                if (r_state != S_IDLE) begin
                    r_tries <= r_tries + TRY_W'(1);
                end
            end
            if (r_ovalid && m_axis_tready && r_state != S_RESP) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd     <= t_cmd'(s_axis_tdata[1:0]);
                        r_conn    <= s_axis_tdata[CONN_W+1:2];
                        r_hdl     <= s_axis_tdata[23:8];
                        r_tries   <= (t_cmd'(s_axis_tdata[1:0]) == CMD_DEQ) ? TRY_W'(1) : '0;
                        r_status  <= ST_EMPTY;
                        r_oconn   <= '0;
                        r_drop    <= '0;
                        r_use_pkt <= 1'b0;
                        r_state   <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (r_cmd)
                        CMD_ENQ: begin
                            r_status <= alu_res.ok ? ST_OK : ST_FULL;
                            r_state  <= S_RESP;
                        end
                        CMD_PURGE: begin
                            r_status <= alu_res.ok ? ST_OK : ST_NOCONN;
                            r_drop   <= alu_res.drop;
                            r_state  <= S_RESP;
                        end
                        CMD_DEQ: begin
                            if (r_rd.ex != '0) begin
                                r_rec   <= r_rd;
                                r_state <= S_SERVE;
                            end else if (r_tries == TRY_W'(TRIES_MAX)) begin
                                r_state <= S_RESP;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_SERVE: begin
                    if (alu_res.again) begin
                        r_rec <= alu_rec;
                    end else if (alu_res.found) begin
                        r_status  <= ST_OK;
                        r_oconn   <= {alu_res.slot, r_bkt};
                        r_use_pkt <= 1'b1;
                        r_state   <= S_RESP;
                    end else if (r_tries == TRY_W'(TRIES_MAX)) begin
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RESP: begin
                    if (ofree) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'd0, r_drop, r_oconn,
                                     (r_use_pkt ? r_pkt : 16'd0), r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_tries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= TRY_W'(TRIES_MAX))
        else $error("dequeue visited more buckets than allowed");

    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SERVE |-> r_rec.rcnt <= RCNT_W'(SLOTS))
        else $error("rotation longer than the bucket");

    a_vis_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SERVE |-> (r_rec.vis & ~r_rec.ex) == '0)
        else $error("visited connection that does not exist");
endmodule
`default_nettype wire
